// ----- hdl/tbfc_pkg.sv -----
package tbfc_pkg;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] TAB_BYTE     = 8'h09;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_DATA = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    localparam logic [1:0] REG_CUT_MODE = 2'd0;
    localparam logic [1:0] REG_DELIM    = 2'd1;
    localparam logic [1:0] REG_SUPPRESS = 2'd2;
    localparam logic [1:0] REG_RCOUNT   = 2'd3;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic       cut_mode;
        logic [7:0] delimiter;
        logic       suppress_undelimited;
        logic [4:0] range_count;
    } cfg_t;

endpackage

// ----- hdl/tbfc_ram.sv -----
module tbfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/tbfc_cfg.sv -----
module tbfc_cfg
    import tbfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg     = cfg_reg;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cut_mode             <= 1'b0;
            cfg_reg.delimiter            <= TAB_BYTE;
            cfg_reg.suppress_undelimited <= 1'b0;
            cfg_reg.range_count          <= 5'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_CUT_MODE: cfg_reg.cut_mode             <= pwdata[0];
                REG_DELIM:    cfg_reg.delimiter            <= pwdata[7:0];
                REG_SUPPRESS: cfg_reg.suppress_undelimited <= pwdata[0];
                REG_RCOUNT:   cfg_reg.range_count          <= pwdata[4:0];
                default:      cfg_reg.cut_mode             <= cfg_reg.cut_mode;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CUT_MODE: prdata = 32'(cfg_reg.cut_mode);
            REG_DELIM:    prdata = 32'(cfg_reg.delimiter);
            REG_SUPPRESS: prdata = 32'(cfg_reg.suppress_undelimited);
            REG_RCOUNT:   prdata = 32'(cfg_reg.range_count);
            default:      prdata = '0;
        endcase
    end

endmodule

// ----- hdl/tbfc_ctrl.sv -----
module tbfc_ctrl
    import tbfc_pkg::*;
#(
    parameter int NUM_RANGES    = 16,
    parameter int LINE_BYTES    = 63,
    parameter int POSITION_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  req_type,
    input  logic [3:0]  range_index,
    input  logic [31:0] range_first,
    input  logic [31:0] range_last,
    input  logic [7:0]  data_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        line_overflow
);

    localparam int CNT_W = $clog2(NUM_RANGES + 1);
    localparam int TA_W  = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int LEN_W = $clog2(LINE_BYTES + 1);
    localparam int LA_W  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int CMP_W = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_TRD    = 11'b00000000010,
        ST_TCMP   = 11'b00000000100,
        ST_BSEL   = 11'b00000001000,
        ST_DRD    = 11'b00000010000,
        ST_DCHK   = 11'b00000100000,
        ST_FSTART = 11'b00001000000,
        ST_LRD    = 11'b00010000000,
        ST_LUSE   = 11'b00100000000,
        ST_TAIL   = 11'b01000000000,
        ST_FIN    = 11'b10000000000
    } state_t;

    state_t                   state_reg, state_next;
    logic                     halted_reg, halted_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] field_reg, field_next;
    logic [POSITION_BITS-1:0] cmp_reg, cmp_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEN_W-1:0]         flen_reg, flen_next;
    logic [LEN_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         tidx_reg, tidx_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic                     sel_reg, sel_next;
    logic                     emitted_reg, emitted_next;
    logic                     nl_reg, nl_next;
    logic                     fctx_reg, fctx_next;
    logic                     whole_reg, whole_next;
    logic [7:0]               byte_reg, byte_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [7:0]               pend_byte_reg, pend_byte_next;
    logic                     pend_ovf_reg, pend_ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic [7:0]               out_byte_reg, out_byte_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic              t_we, t_re;
    logic [TA_W-1:0]   t_waddr, t_raddr;
    logic [63:0]       t_rdata;
    logic              l_we, l_re;
    logic [LA_W-1:0]   l_raddr;
    logic [7:0]        l_rdata;

    logic              accept, can_push, gen_req, gen_ok, push, push_last;
    logic [7:0]        gen_byte;
    logic [7:0]        rc_ext;
    logic [CNT_W-1:0]  n_now;
    logic [TA_W+3:0]   ri_ext;
    logic [CMP_W-1:0]  cmp_ext, tf_ext, tl_ext;
    logic              hit;
    logic [POSITION_BITS-1:0] fld_inc;

    tbfc_ram #(.WIDTH(64), .DEPTH(NUM_RANGES)) u_table (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata ({range_first, range_last}),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    tbfc_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line (
        .clk   (clk),
        .we    (l_we),
        .waddr (len_reg[LA_W-1:0]),
        .wdata (data_byte),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    assign req_ready     = (state_reg == ST_IDLE);
    assign accept        = req_valid && req_ready;
    assign res_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last_of_run   = out_last_reg;
    assign line_overflow = out_ovf_reg;

    assign can_push = !out_valid_reg || res_ready;
    assign gen_ok   = !pend_valid_reg || can_push;

    assign rc_ext  = {3'b000, cfg.range_count};
    assign n_now   = (rc_ext > 8'(NUM_RANGES)) ? CNT_W'(NUM_RANGES) : rc_ext[CNT_W-1:0];
    assign ri_ext  = {{TA_W{1'b0}}, range_index};
    assign t_waddr = ri_ext[TA_W-1:0];

    assign cmp_ext = CMP_W'(cmp_reg);
    assign tf_ext  = CMP_W'(t_rdata[63:32]);
    assign tl_ext  = CMP_W'(t_rdata[31:0]);
    assign hit     = (cmp_ext >= tf_ext) && ((tl_ext == '0) || (cmp_ext <= tl_ext));
    assign fld_inc = (field_reg != '1) ? field_reg + 1'b1 : field_reg;

    always_comb
    begin
        state_next   = state_reg;
        halted_next  = halted_reg;
        pos_next     = pos_reg;
        field_next   = field_reg;
        cmp_next     = cmp_reg;
        len_next     = len_reg;
        flen_next    = flen_reg;
        idx_next     = idx_reg;
        tidx_next    = tidx_reg;
        n_next       = n_reg;
        sel_next     = sel_reg;
        emitted_next = emitted_reg;
        nl_next      = nl_reg;
        fctx_next    = fctx_reg;
        whole_next   = whole_reg;
        byte_next    = byte_reg;
        t_we         = 1'b0;
        t_re         = 1'b0;
        t_raddr      = tidx_reg[TA_W-1:0];
        l_we         = 1'b0;
        l_re         = 1'b0;
        l_raddr      = idx_reg[LA_W-1:0];
        gen_req      = 1'b0;
        gen_byte     = l_rdata;
        push_last    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !halted_reg)
                begin
                    n_next = n_now;
                    case (req_type)
                        REQ_LOAD:
                        begin
                            t_we = ri_ext < (TA_W+4)'(NUM_RANGES);
                        end
                        REQ_DATA:
                        begin
                            if (!cfg.cut_mode)
                            begin
                                if (data_byte == NEWLINE_BYTE)
                                begin
                                    gen_req    = 1'b1;
                                    gen_byte   = NEWLINE_BYTE;
                                    pos_next   = POSITION_BITS'(1);
                                    state_next = ST_FIN;
                                end
                                else
                                begin
                                    byte_next = data_byte;
                                    cmp_next  = pos_reg;
                                    fctx_next = 1'b0;
                                    sel_next  = 1'b0;
                                    tidx_next = '0;
                                    if (pos_reg != '1)
                                    begin
                                        pos_next = pos_reg + 1'b1;
                                    end
                                    state_next = (n_now == '0) ? ST_FIN : ST_TRD;
                                end
                            end
                            else if (data_byte == NEWLINE_BYTE)
                            begin
                                flen_next  = len_reg;
                                len_next   = '0;
                                nl_next    = 1'b1;
                                idx_next   = '0;
                                state_next = ST_DRD;
                            end
                            else if (len_reg >= LEN_W'(LINE_BYTES))
                            begin
                                // overflow: one flagged word, then halt
                                halted_next = 1'b1;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                l_we     = 1'b1;
                                len_next = len_reg + 1'b1;
                            end
                        end
                        REQ_END:
                        begin
                            pos_next = POSITION_BITS'(1);
                            len_next = '0;
                            if (cfg.cut_mode && (len_reg != '0))
                            begin
                                flen_next  = len_reg;
                                nl_next    = 1'b0;
                                idx_next   = '0;
                                state_next = ST_DRD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TRD:
            begin
                t_re       = 1'b1;
                state_next = ST_TCMP;
            end
            ST_TCMP:
            begin
                if (hit)
                begin
                    sel_next   = 1'b1;
                    state_next = fctx_reg ? ST_FSTART : ST_BSEL;
                end
                else if (tidx_reg + 1'b1 == n_reg)
                begin
                    sel_next   = 1'b0;
                    state_next = fctx_reg ? ST_FSTART : ST_BSEL;
                end
                else
                begin
                    tidx_next  = tidx_reg + 1'b1;
                    state_next = ST_TRD;
                end
            end
            ST_BSEL:
            begin
                gen_req    = sel_reg;
                gen_byte   = byte_reg;
                state_next = ST_FIN;
            end
            ST_DRD:
            begin
                if (idx_reg == flen_reg)
                begin
                    if (cfg.suppress_undelimited)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        whole_next = 1'b1;
                        idx_next   = '0;
                        state_next = ST_LRD;
                    end
                end
                else
                begin
                    l_re       = 1'b1;
                    state_next = ST_DCHK;
                end
            end
            ST_DCHK:
            begin
                if (l_rdata == cfg.delimiter)
                begin
                    whole_next   = 1'b0;
                    idx_next     = '0;
                    field_next   = POSITION_BITS'(1);
                    cmp_next     = POSITION_BITS'(1);
                    emitted_next = 1'b0;
                    fctx_next    = 1'b1;
                    sel_next     = 1'b0;
                    tidx_next    = '0;
                    state_next   = (n_reg == '0) ? ST_FSTART : ST_TRD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DRD;
                end
            end
            ST_FSTART:
            begin
                if (sel_reg && emitted_reg)
                begin
                    gen_req  = 1'b1;
                    gen_byte = cfg.delimiter;
                    if (gen_ok)
                    begin
                        state_next = ST_LRD;
                    end
                end
                else
                begin
                    emitted_next = emitted_reg | sel_reg;
                    state_next   = ST_LRD;
                end
            end
            ST_LRD:
            begin
                if (idx_reg == flen_reg)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    l_re       = 1'b1;
                    state_next = ST_LUSE;
                end
            end
            ST_LUSE:
            begin
                if (!whole_reg && (l_rdata == cfg.delimiter))
                begin
                    idx_next   = idx_reg + 1'b1;
                    field_next = fld_inc;
                    cmp_next   = fld_inc;
                    sel_next   = 1'b0;
                    tidx_next  = '0;
                    state_next = (n_reg == '0) ? ST_FSTART : ST_TRD;
                end
                else if (whole_reg || sel_reg)
                begin
                    gen_req = 1'b1;
                    if (gen_ok)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_LRD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LRD;
                end
            end
            ST_TAIL:
            begin
                if (nl_reg)
                begin
                    gen_req  = 1'b1;
                    gen_byte = NEWLINE_BYTE;
                    if (gen_ok)
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_push)
                begin
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // one word is held back so the final word of a run can carry its mark
    always_comb
    begin
        push            = push_last || (gen_req && gen_ok && pend_valid_reg);
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_ovf_next   = pend_ovf_reg;
        if (push_last)
        begin
            pend_valid_next = 1'b0;
        end
        if (gen_req && gen_ok)
        begin
            pend_valid_next = 1'b1;
            pend_byte_next  = gen_byte;
            pend_ovf_next   = 1'b0;
        end
        if ((state_reg == ST_IDLE) && halted_next && !halted_reg)
        begin
            pend_valid_next = 1'b1;
            pend_byte_next  = 8'h00;
            pend_ovf_next   = 1'b1;
        end
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = pend_byte_reg;
            out_last_next  = push_last;
            out_ovf_next   = pend_ovf_reg;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            halted_reg     <= 1'b0;
            pos_reg        <= POSITION_BITS'(1);
            len_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            halted_reg     <= halted_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        field_reg     <= field_next;
        cmp_reg       <= cmp_next;
        flen_reg      <= flen_next;
        idx_reg       <= idx_next;
        tidx_reg      <= tidx_next;
        n_reg         <= n_next;
        sel_reg       <= sel_next;
        emitted_reg   <= emitted_next;
        nl_reg        <= nl_next;
        fctx_reg      <= fctx_next;
        whole_reg     <= whole_next;
        byte_reg      <= byte_next;
        pend_byte_reg <= pend_byte_next;
        pend_ovf_reg  <= pend_ovf_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

// ----- hdl/text_byte_field_cutter_top.sv -----
// Byte mode: a data word scans the range entries in turn (up to 16) until one hits;
// a newline or an empty range table skips the scan.
// Field mode: a stored byte is written to the line store; a line flush first searches
// the stored bytes for the delimiter, then reads them out, and for each field of a
// delimited line scans the range entries.
// One item is worked at a time; table and line store are single-port reads.
// Reset (rst_n low, asynchronous) clears control, position to one, line empty,
// registers to defaults; table and line store contents stay undefined until written.
module text_byte_field_cutter_top
    import tbfc_pkg::*;
#(
    parameter int NUM_RANGES    = 16,
    parameter int LINE_BYTES    = 63,
    parameter int POSITION_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // request channel
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [1:0]        req_type,
    input  logic [3:0]        range_index,
    input  logic [31:0]       range_first,
    input  logic [31:0]       range_last,
    input  logic [7:0]        data_byte,
    // result channel
    output logic              res_valid,
    input  logic              res_ready,
    output logic [7:0]        out_byte,
    output logic              last_of_run,
    output logic              line_overflow
);

    cfg_t cfg;

    // register file: mode, delimiter, suppression, range count
    tbfc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer around the range table and line store memories;
    // each word goes out through a holding stage and an output register
    tbfc_ctrl #(
        .NUM_RANGES    (NUM_RANGES),
        .LINE_BYTES    (LINE_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .range_index   (range_index),
        .range_first   (range_first),
        .range_last    (range_last),
        .data_byte     (data_byte),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .line_overflow (line_overflow)
    );

endmodule

// ----- hdl/tbfc_checker.sv -----
module tbfc_checker
    import tbfc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       line_overflow
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte))
        else $error("result word changed while stalled");

    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && line_overflow |-> last_of_run && (out_byte == 8'h00))
        else $error("overflow word not final");

    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && line_overflow |=> !res_valid)
        else $error("word after overflow");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready && res_valid |-> last_of_run)
        else $error("ready while a run is unfinished");

endmodule

bind text_byte_field_cutter_top tbfc_checker u_tbfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req_ready),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .line_overflow (line_overflow)
);
